@@ hw/rtl/srclip_pkg.sv @@
package srclip_pkg;

    // Coordinate and difference widths are fixed by the field formats (Q12.4).
    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int NUM_EDGES   = 4;

    // Configuration port geometry.
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 4;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_TOP    = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    // Edge order used for the p and q terms.
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_RIGHT  = 1;
    localparam int EDGE_TOP    = 2;
    localparam int EDGE_BOTTOM = 3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] left;
        logic signed [COORD_WIDTH-1:0] top;
        logic signed [COORD_WIDTH-1:0] right;
        logic signed [COORD_WIDTH-1:0] bottom;
    } t_rect;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
    } t_seg_in;

    typedef struct packed {
        logic                          visible;
        logic signed [COORD_WIDTH-1:0] clip_start_x;
        logic signed [COORD_WIDTH-1:0] clip_start_y;
        logic signed [COORD_WIDTH-1:0] clip_end_x;
        logic signed [COORD_WIDTH-1:0] clip_end_y;
    } t_seg_out;

    // Per-segment data carried alongside the dividers.
    typedef struct packed {
        logic signed [DIFF_WIDTH-1:0] x0;
        logic signed [DIFF_WIDTH-1:0] y0;
        logic signed [DIFF_WIDTH-1:0] dx;
        logic signed [DIFF_WIDTH-1:0] dy;
        logic [NUM_EDGES-1:0]         pzero;
        logic [NUM_EDGES-1:0]         pneg;
        logic                         rej;
    } t_side;

endpackage

@@ hw/rtl/srclip_cfg.sv @@
module srclip_cfg (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [srclip_pkg::APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [srclip_pkg::APB_DATA_WIDTH-1:0]     pwdata,
    output logic [srclip_pkg::APB_DATA_WIDTH-1:0]     prdata,
    output logic                                      pready,
    output srclip_pkg::t_rect                         o_rect
);

    srclip_pkg::t_rect r_rect;
    logic              wr_en;
    logic [1:0]        reg_idx;
    logic signed [srclip_pkg::COORD_WIDTH-1:0] rd_val;
    logic signed [srclip_pkg::COORD_WIDTH-1:0] wr_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign wr_val  = pwdata[srclip_pkg::COORD_WIDTH-1:0];

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                srclip_pkg::REG_LEFT:   r_rect.left   <= wr_val;
                srclip_pkg::REG_TOP:    r_rect.top    <= wr_val;
                srclip_pkg::REG_RIGHT:  r_rect.right  <= wr_val;
                srclip_pkg::REG_BOTTOM: r_rect.bottom <= wr_val;
                default: ;
            endcase
        end
    end

    // Read data is sign extended to the bus width.
    always_comb begin
        case (reg_idx)
            srclip_pkg::REG_LEFT:   rd_val = r_rect.left;
            srclip_pkg::REG_TOP:    rd_val = r_rect.top;
            srclip_pkg::REG_RIGHT:  rd_val = r_rect.right;
            srclip_pkg::REG_BOTTOM: rd_val = r_rect.bottom;
            default:                rd_val = '0;
        endcase
    end

    assign prdata = srclip_pkg::APB_DATA_WIDTH'(rd_val);
    assign o_rect = r_rect;

endmodule

@@ hw/rtl/srclip_div.sv @@
module srclip_div #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [srclip_pkg::DIFF_WIDTH-1:0] i_q,
    input  logic signed [srclip_pkg::DIFF_WIDTH-1:0] i_p,
    output logic signed [T_FRAC_BITS+1:0]          o_t
);

    localparam int DW = srclip_pkg::DIFF_WIDTH;
    localparam int QB = T_FRAC_BITS + 2;
    localparam int CW = DW + T_FRAC_BITS + 2;

    // Magnitudes, quotient sign and overflow flag.
    logic [DW-1:0] r_absq;
    logic [DW-1:0] r_absp;
    logic          r_neg;
    logic          r_ovf;
    logic [DW-1:0] n_absq;
    logic [DW-1:0] n_absp;

    assign n_absq = i_q[DW-1] ? DW'(-i_q) : DW'(i_q);
    assign n_absp = i_p[DW-1] ? DW'(-i_p) : DW'(i_p);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_absq <= n_absq;
            r_absp <= n_absp;
            r_neg  <= i_q[DW-1] ^ i_p[DW-1];
            r_ovf  <= ({2'b00, n_absq} >= {n_absp, 2'b00});
        end
    end

    // One quotient bit per stage, most significant first.
    logic [CW-1:0] r_rem [QB];
    logic [DW-1:0] r_dvs [QB];
    logic [QB-1:0] r_quo [QB];
    logic          r_sneg [QB];
    logic          r_sovf [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [CW-1:0] rem_in;
        logic [DW-1:0] dvs_in;
        logic [QB-1:0] quo_in;
        logic          neg_in;
        logic          ovf_in;
        logic [CW-1:0] sub;
        logic          ge;
        logic [QB-1:0] n_quo;

        if (k == 0) begin : g_first
            assign rem_in = CW'(r_absq) << T_FRAC_BITS;
            assign dvs_in = r_absp;
            assign quo_in = '0;
            assign neg_in = r_neg;
            assign ovf_in = r_ovf;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign dvs_in = r_dvs[k-1];
            assign quo_in = r_quo[k-1];
            assign neg_in = r_sneg[k-1];
            assign ovf_in = r_sovf[k-1];
        end

        assign sub = CW'(dvs_in) << (QB - 1 - k);
        assign ge  = (rem_in >= sub);

        always_comb begin
            n_quo              = quo_in;
            n_quo[QB - 1 - k]  = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (rem_in - sub) : rem_in;
                r_dvs[k]  <= dvs_in;
                r_quo[k]  <= n_quo;
                r_sneg[k] <= neg_in;
                r_sovf[k] <= ovf_in;
            end
        end
    end

    // Apply the sign and saturate to [-2, 2).
    logic [QB-1:0]         mag;
    logic                  fneg;
    logic                  fovf;
    logic signed [QB-1:0]  n_t;
    logic signed [QB-1:0]  r_t;

    assign mag  = r_quo[QB-1];
    assign fneg = r_sneg[QB-1];
    assign fovf = r_sovf[QB-1];

    always_comb begin
        if (!fneg) begin
            if (fovf || mag[QB-1]) begin
                n_t = {1'b0, {(QB-1){1'b1}}};
            end else begin
                n_t = mag;
            end
        end else begin
            if (fovf || (mag[QB-1] && |mag[QB-2:0])) begin
                n_t = {1'b1, {(QB-1){1'b0}}};
            end else begin
                n_t = ~mag + QB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= n_t;
        end
    end

    assign o_t = r_t;

endmodule

@@ hw/rtl/srclip_lerp.sv @@
module srclip_lerp #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_valid,
    input  logic                                     i_ok,
    input  logic signed [srclip_pkg::DIFF_WIDTH-1:0] i_x0,
    input  logic signed [srclip_pkg::DIFF_WIDTH-1:0] i_y0,
    input  logic signed [srclip_pkg::DIFF_WIDTH-1:0] i_dx,
    input  logic signed [srclip_pkg::DIFF_WIDTH-1:0] i_dy,
    input  logic signed [T_FRAC_BITS+1:0]            i_t_in,
    input  logic signed [T_FRAC_BITS+1:0]            i_t_out,
    output logic                                     o_valid,
    output srclip_pkg::t_seg_out                     o_data
);

    localparam int CW = srclip_pkg::COORD_WIDTH;
    localparam int DW = srclip_pkg::DIFF_WIDTH;
    localparam int TW = T_FRAC_BITS + 2;
    localparam int PW = DW + TW;
    localparam int RW = PW + 1;
    localparam int OW = RW - T_FRAC_BITS;
    localparam int SW = OW + 1;
    localparam logic signed [RW-1:0] HALF = RW'(1) << (T_FRAC_BITS - 1);

    // Round half up, add the start point and saturate to the coordinate range.
    function automatic logic signed [CW-1:0] place(
        input logic signed [CW-1:0] s,
        input logic signed [PW-1:0] prod
    );
        logic signed [RW-1:0] sum;
        logic signed [OW-1:0] off;
        logic signed [SW-1:0] r;
        sum = RW'(prod) + HALF;
        off = OW'(sum >>> T_FRAC_BITS);
        r   = SW'(s) + SW'(off);
        if (&r[SW-1:CW-1] || ~|r[SW-1:CW-1]) begin
            place = r[CW-1:0];
        end else if (r[SW-1]) begin
            place = {1'b1, {(CW-1){1'b0}}};
        end else begin
            place = {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    // Multiply stage.
    logic                 r_m_valid;
    logic                 r_m_ok;
    logic signed [CW-1:0] r_m_x0;
    logic signed [CW-1:0] r_m_y0;
    logic signed [PW-1:0] r_m_sx;
    logic signed [PW-1:0] r_m_sy;
    logic signed [PW-1:0] r_m_ex;
    logic signed [PW-1:0] r_m_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_ok <= i_ok;
            r_m_x0 <= CW'(i_x0);
            r_m_y0 <= CW'(i_y0);
            r_m_sx <= PW'(i_dx) * PW'(i_t_in);
            r_m_sy <= PW'(i_dy) * PW'(i_t_in);
            r_m_ex <= PW'(i_dx) * PW'(i_t_out);
            r_m_ey <= PW'(i_dy) * PW'(i_t_out);
        end
    end

    // Round and place stage; hidden segments report zero coordinates.
    logic                 r_valid;
    srclip_pkg::t_seg_out r_data;
    srclip_pkg::t_seg_out n_data;

    always_comb begin
        if (r_m_ok) begin
            n_data.visible      = 1'b1;
            n_data.clip_start_x = place(r_m_x0, r_m_sx);
            n_data.clip_start_y = place(r_m_y0, r_m_sy);
            n_data.clip_end_x   = place(r_m_x0, r_m_ex);
            n_data.clip_end_y   = place(r_m_y0, r_m_ey);
        end else begin
            n_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hw/rtl/segment_rect_clipper_top.sv @@
// Segment clipper against an axis-aligned rectangle (Liang-Barsky, fixed point).
// Input channel: i_in_valid / o_in_stall carry one segment per beat in
// i_in_data; a beat is taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry one result per segment in
// o_out_data, in input order.
// Configuration: APB port, rect_left/top/right/bottom at byte addresses
// 0, 4, 8, 12; write only while no segment is in flight.
// Stages: setup, then the pipelined dividers, which resolve one quotient bit
// per stage, then select, multiply and round.
// Throughput: one segment per cycle while the skid register is empty.
// Reset (synchronous, active low) clears the rectangle to zero and empties
// the pipeline; no output beat is presented until a segment has passed.
// When the receiver stalls, the pending result moves into a skid register and
// the pipeline freezes the next cycle; o_in_stall follows that register, so
// nothing is lost or repeated.
module segment_rect_clipper_top #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  srclip_pkg::t_seg_in                       i_in_data,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output srclip_pkg::t_seg_out                      o_out_data,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [srclip_pkg::APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [srclip_pkg::APB_DATA_WIDTH-1:0]     pwdata,
    output logic [srclip_pkg::APB_DATA_WIDTH-1:0]     prdata,
    output logic                                      pready
);

    localparam int DW    = srclip_pkg::DIFF_WIDTH;
    localparam int NE    = srclip_pkg::NUM_EDGES;
    localparam int TW    = T_FRAC_BITS + 2;
    localparam int L_DIV = T_FRAC_BITS + 4;
    localparam logic signed [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

    srclip_pkg::t_rect rect;
    logic              en;
    logic              r_skid_valid;

    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    srclip_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rect  (rect)
    );

    // Setup stage: differences and edge distances.
    logic                 r_s1_valid;
    logic signed [DW-1:0] r_s1_x0;
    logic signed [DW-1:0] r_s1_y0;
    logic signed [DW-1:0] r_s1_dx;
    logic signed [DW-1:0] r_s1_dy;
    logic signed [DW-1:0] r_s1_p [NE];
    logic signed [DW-1:0] r_s1_q [NE];
    logic signed [DW-1:0] x0;
    logic signed [DW-1:0] y0;
    logic signed [DW-1:0] x1;
    logic signed [DW-1:0] y1;

    assign x0 = DW'(i_in_data.start_x);
    assign y0 = DW'(i_in_data.start_y);
    assign x1 = DW'(i_in_data.end_x);
    assign y1 = DW'(i_in_data.end_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_x0 <= x0;
            r_s1_y0 <= y0;
            r_s1_dx <= x1 - x0;
            r_s1_dy <= y1 - y0;
            r_s1_p[srclip_pkg::EDGE_LEFT]   <= x0 - x1;
            r_s1_q[srclip_pkg::EDGE_LEFT]   <= x0 - DW'(rect.left);
            r_s1_p[srclip_pkg::EDGE_RIGHT]  <= x1 - x0;
            r_s1_q[srclip_pkg::EDGE_RIGHT]  <= DW'(rect.right) - x0;
            r_s1_p[srclip_pkg::EDGE_TOP]    <= y0 - y1;
            r_s1_q[srclip_pkg::EDGE_TOP]    <= y0 - DW'(rect.top);
            r_s1_p[srclip_pkg::EDGE_BOTTOM] <= y1 - y0;
            r_s1_q[srclip_pkg::EDGE_BOTTOM] <= DW'(rect.bottom) - y0;
        end
    end

    // One divider lane per edge.
    logic signed [TW-1:0] t_edge [NE];

    for (genvar e = 0; e < NE; e++) begin : g_lane
        srclip_div #(
            .T_FRAC_BITS (T_FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_q   (r_s1_q[e]),
            .i_p   (r_s1_p[e]),
            .o_t   (t_edge[e])
        );
    end

    // Segment data and edge flags travel beside the dividers.
    srclip_pkg::t_side n_side;
    srclip_pkg::t_side r_sb [L_DIV];
    logic              r_sb_valid [L_DIV];

    always_comb begin
        n_side.x0  = r_s1_x0;
        n_side.y0  = r_s1_y0;
        n_side.dx  = r_s1_dx;
        n_side.dy  = r_s1_dy;
        n_side.rej = 1'b0;
        for (int e = 0; e < NE; e++) begin
            n_side.pzero[e] = (r_s1_p[e] == '0);
            n_side.pneg[e]  = r_s1_p[e][DW-1];
            if (n_side.pzero[e] && r_s1_q[e][DW-1]) begin
                n_side.rej = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L_DIV; k++) begin
                r_sb_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_sb_valid[0] <= r_s1_valid;
            for (int k = 1; k < L_DIV; k++) begin
                r_sb_valid[k] <= r_sb_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= n_side;
            for (int k = 1; k < L_DIV; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // Select stage: entering parameter is the largest, leaving the smallest.
    srclip_pkg::t_side    sd;
    logic signed [TW-1:0] n_t_in;
    logic signed [TW-1:0] n_t_out;
    logic                 r_sel_valid;
    logic                 r_sel_ok;
    logic signed [DW-1:0] r_sel_x0;
    logic signed [DW-1:0] r_sel_y0;
    logic signed [DW-1:0] r_sel_dx;
    logic signed [DW-1:0] r_sel_dy;
    logic signed [TW-1:0] r_sel_t_in;
    logic signed [TW-1:0] r_sel_t_out;

    assign sd = r_sb[L_DIV-1];

    always_comb begin
        n_t_in  = '0;
        n_t_out = T_ONE;
        for (int e = 0; e < NE; e++) begin
            if (!sd.pzero[e]) begin
                if (sd.pneg[e]) begin
                    if (t_edge[e] > n_t_in) begin
                        n_t_in = t_edge[e];
                    end
                end else begin
                    if (t_edge[e] < n_t_out) begin
                        n_t_out = t_edge[e];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_valid <= 1'b0;
        end else if (en) begin
            r_sel_valid <= r_sb_valid[L_DIV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sel_ok    <= !sd.rej && (n_t_in <= n_t_out);
            r_sel_x0    <= sd.x0;
            r_sel_y0    <= sd.y0;
            r_sel_dx    <= sd.dx;
            r_sel_dy    <= sd.dy;
            r_sel_t_in  <= n_t_in;
            r_sel_t_out <= n_t_out;
        end
    end

    // Interpolate the clipped endpoints.
    logic                 lerp_valid;
    srclip_pkg::t_seg_out lerp_data;

    srclip_lerp #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sel_valid),
        .i_ok    (r_sel_ok),
        .i_x0    (r_sel_x0),
        .i_y0    (r_sel_y0),
        .i_dx    (r_sel_dx),
        .i_dy    (r_sel_dy),
        .i_t_in  (r_sel_t_in),
        .i_t_out (r_sel_t_out),
        .o_valid (lerp_valid),
        .o_data  (lerp_data)
    );

    // Skid register holds a stalled beat while the pipeline freezes.
    srclip_pkg::t_seg_out r_skid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_out_stall) begin
                r_skid_valid <= 1'b0;
            end
        end else if (lerp_valid && i_out_stall) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid_data <= lerp_data;
        end
    end

    assign o_out_valid = r_skid_valid || lerp_valid;
    assign o_out_data  = r_skid_valid ? r_skid_data : lerp_data;

`ifndef SYNTH
    // A full skid register always presents a beat.
    a_skid_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> o_out_valid)
        else $error("skid register full without output beat");

    // The skid register fills only after a stalled beat.
    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(i_out_stall) && $past(lerp_valid))
        else $error("skid register filled without a stall");

    // Hidden segments carry zero coordinates.
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.visible) |->
            (o_out_data.clip_start_x == '0 && o_out_data.clip_start_y == '0 &&
             o_out_data.clip_end_x == '0 && o_out_data.clip_end_y == '0))
        else $error("hidden segment with nonzero coordinates");
`endif

endmodule
